@@ rtl/core/linear_probe_hash_table_core_defines.svh @@
// Assertion macros shared by the core's modules.
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_DEFINES_SVH

// The property must hold at every edge out of reset.
`define LPHT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/lpht_pkg.sv @@
`timescale 1ns / 1ps
package lpht_pkg;

  localparam int TableOrder = 8;
  localparam int KeyBits    = 32;
  localparam int DataBits   = 32;

  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_NOP    = 2'd3;

  localparam logic [1:0] TAG_EMPTY = 2'd0;
  localparam logic [1:0] TAG_LIVE  = 2'd1;
  localparam logic [1:0] TAG_TOMB  = 2'd2;

  localparam logic [2:0] ST_MISS     = 3'd0;
  localparam logic [2:0] ST_FOUND    = 3'd1;
  localparam logic [2:0] ST_INSERTED = 3'd2;
  localparam logic [2:0] ST_REMOVED  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  // Command from the front part to the probe engine.
  typedef struct packed {
    logic [1:0]  action;
    logic        replace;
    logic [63:0] key;
    logic [31:0] hash;
    logic [63:0] data;
  } cmd_t;

endpackage

@@ rtl/core/lpht_ram.sv @@
`timescale 1ns / 1ps
module lpht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/lpht_front.sv @@
`timescale 1ns / 1ps
`include "linear_probe_hash_table_core_defines.svh"
module lpht_front #(
  parameter int KEY_BITS  = lpht_pkg::KeyBits,
  parameter int DATA_BITS = lpht_pkg::DataBits
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [103:0]   in_tdata,
  input  logic [1:0]     in_tuser,
  output logic           cmd_valid,
  input  logic           cmd_ready,
  output lpht_pkg::cmd_t cmd
);

  // Two-entry queue between the input side and the probe engine.
  lpht_pkg::cmd_t q_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  lpht_pkg::cmd_t c;
  logic           push, pop;

  always_comb begin
    c         = '0;
    c.action  = in_tuser;
    c.replace = in_tdata[0];
    c.key     = {32'd0, in_tdata[32:1]} & ((64'd1 << KEY_BITS) - 64'd1);
    c.hash    = in_tdata[64:33];
    c.data    = {32'd0, in_tdata[96:65]} & ((64'd1 << DATA_BITS) - 64'd1);
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= c;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  `LPHT_ASSERT(a_cnt_range, clk, rst_n, cnt_r != 2'd3, "queue count out of range")
  `LPHT_ASSERT_NEXT(a_push_grow, clk, rst_n, push && !pop, cnt_r == $past(cnt_r) + 2'd1, "push lost")
  `LPHT_ASSERT(a_ptr_cnt, clk, rst_n, (cnt_r == 2'd1) == (wp_r != rp_r), "pointer mismatch")

endmodule

@@ rtl/core/lpht_engine.sv @@
`timescale 1ns / 1ps
`include "linear_probe_hash_table_core_defines.svh"
module lpht_engine #(
  parameter int TABLE_ORDER = lpht_pkg::TableOrder,
  parameter int KEY_BITS    = lpht_pkg::KeyBits,
  parameter int DATA_BITS   = lpht_pkg::DataBits
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  lpht_pkg::cmd_t cmd,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [47:0]    out_tdata
);

  localparam int AW = TABLE_ORDER;
  localparam int SlotCount = 1 << TABLE_ORDER;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_CHECK, S_WRITE, S_OUT
  } state_t;

  state_t         state_r;
  lpht_pkg::cmd_t cmd_r;
  logic [AW-1:0]  addr_r, spot_r, wr_addr_r;
  logic [AW:0]    step_r;
  logic           has_spot_r;
  logic [AW:0]    count_r;
  logic [2:0]     status_r;
  logic [31:0]    dout_r;

  logic            tag_we, kd_we;
  logic [AW-1:0]   tag_wa;
  logic [1:0]      tag_wd, tag_rd;
  logic [AW-1:0]   rd_addr;
  logic [KEY_BITS-1:0]  key_rd;
  logic [DATA_BITS-1:0] data_rd, data_wd;
  logic                 key_we;

  logic [1:0]    tag_wd_r;
  logic          tag_we_r, key_we_r, data_we_r;
  logic [DATA_BITS-1:0] data_wd_r;

  assign rd_addr = addr_r;
  assign tag_we  = tag_we_r;
  assign tag_wa  = wr_addr_r;
  assign tag_wd  = tag_wd_r;
  assign key_we  = key_we_r;
  assign kd_we   = data_we_r;
  assign data_wd = data_wd_r;

  lpht_ram #(.WIDTH(2), .DEPTH(SlotCount)) u_tag (
    .clk(clk), .we(tag_we), .waddr(tag_wa), .wdata(tag_wd),
    .raddr(rd_addr), .rdata(tag_rd));
  lpht_ram #(.WIDTH(KEY_BITS), .DEPTH(SlotCount)) u_key (
    .clk(clk), .we(key_we), .waddr(tag_wa), .wdata(cmd_r.key[KEY_BITS-1:0]),
    .raddr(rd_addr), .rdata(key_rd));
  lpht_ram #(.WIDTH(DATA_BITS), .DEPTH(SlotCount)) u_data (
    .clk(clk), .we(kd_we), .waddr(tag_wa), .wdata(data_wd),
    .raddr(rd_addr), .rdata(data_rd));

  assign cmd_ready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {4'd0, 9'(count_r), dout_r, status_r};

  logic key_hit;
  assign key_hit = (key_rd == cmd_r.key[KEY_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      addr_r     <= '0;
      wr_addr_r  <= '0;
      tag_we_r   <= 1'b1;
      tag_wd_r   <= lpht_pkg::TAG_EMPTY;
      key_we_r   <= 1'b0;
      data_we_r  <= 1'b0;
      count_r    <= '0;
      step_r     <= '0;
      has_spot_r <= 1'b0;
    end else begin
      tag_we_r  <= 1'b0;
      key_we_r  <= 1'b0;
      data_we_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          // One slot a cycle is marked empty after reset.
          if (wr_addr_r == AW'(SlotCount - 1)) begin
            state_r <= S_IDLE;
          end else begin
            wr_addr_r <= wr_addr_r + AW'(1);
            tag_we_r  <= 1'b1;
            tag_wd_r  <= lpht_pkg::TAG_EMPTY;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r      <= cmd;
            addr_r     <= cmd.hash[AW-1:0];
            step_r     <= '0;
            has_spot_r <= 1'b0;
            status_r   <= lpht_pkg::ST_MISS;
            dout_r     <= '0;
            state_r    <= S_READ;
          end
        end
        S_READ: state_r <= S_CHECK;
        S_CHECK: begin
          state_r <= S_OUT;
          if (!(cmd_r.action inside {lpht_pkg::ACT_LOOKUP, lpht_pkg::ACT_INSERT,
                                     lpht_pkg::ACT_REMOVE})) begin
            status_r <= lpht_pkg::ST_MISS;
          end else if (tag_rd == lpht_pkg::TAG_LIVE && key_hit) begin
            wr_addr_r <= addr_r;
            case (cmd_r.action)
              lpht_pkg::ACT_REMOVE: begin
                status_r <= lpht_pkg::ST_REMOVED;
                tag_we_r <= 1'b1;
                tag_wd_r <= lpht_pkg::TAG_TOMB;
                if (count_r != '0) count_r <= count_r - (AW+1)'(1);
              end
              lpht_pkg::ACT_INSERT: begin
                status_r <= lpht_pkg::ST_FOUND;
                if (cmd_r.replace) begin
                  data_we_r <= 1'b1;
                  data_wd_r <= cmd_r.data[DATA_BITS-1:0];
                  dout_r    <= 32'(cmd_r.data[DATA_BITS-1:0]);
                end else begin
                  dout_r <= 32'(data_rd);
                end
              end
              default: begin
                status_r <= lpht_pkg::ST_FOUND;
                dout_r   <= 32'(data_rd);
              end
            endcase
          end else if (tag_rd == lpht_pkg::TAG_EMPTY
                       || step_r == (AW+1)'(SlotCount - 1)) begin
            // End of the probe path: empty slot or every slot seen.
            if (cmd_r.action == lpht_pkg::ACT_INSERT) begin
              if (has_spot_r || tag_rd != lpht_pkg::TAG_LIVE) begin
                wr_addr_r <= has_spot_r ? spot_r : addr_r;
                tag_we_r  <= 1'b1;
                tag_wd_r  <= lpht_pkg::TAG_LIVE;
                key_we_r  <= 1'b1;
                data_we_r <= 1'b1;
                data_wd_r <= cmd_r.data[DATA_BITS-1:0];
                dout_r    <= 32'(cmd_r.data[DATA_BITS-1:0]);
                count_r   <= count_r + (AW+1)'(1);
                status_r  <= lpht_pkg::ST_INSERTED;
              end else begin
                status_r <= lpht_pkg::ST_FULL;
              end
            end
          end else begin
            if (tag_rd != lpht_pkg::TAG_LIVE && !has_spot_r) begin
              has_spot_r <= 1'b1;
              spot_r     <= addr_r;
            end
            addr_r  <= addr_r + AW'(1);
            step_r  <= step_r + (AW+1)'(1);
            state_r <= S_READ;
          end
        end
        S_OUT: if (out_tready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `LPHT_ASSERT(a_one_busy, clk, rst_n, !(cmd_ready && out_tvalid), "ready while holding result")
  `LPHT_ASSERT(a_count_max, clk, rst_n, count_r <= (AW+1)'(SlotCount), "live count overflow")
  `LPHT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result dropped")

endmodule

@@ rtl/core/linear_probe_hash_table_core.sv @@
`timescale 1ns / 1ps
// Channel  Direction  Handshake          Payload
// in_      slave      in_tvalid/tready   tdata: replace,key,hash,data; tuser: action
// out_     master     out_tvalid/tready  tdata: status,data_out,live_count
// Each slot probed takes a read state and a check state, set by the single read port of
// the slot memories; the engine takes no new item until the last result is taken.
// After reset a clearing pass marks every slot empty before the first item is taken.
// A two-word queue takes input while the probe engine works or its result waits.
module linear_probe_hash_table_core #(
  parameter int TABLE_ORDER = lpht_pkg::TableOrder,
  parameter int KEY_BITS    = lpht_pkg::KeyBits,
  parameter int DATA_BITS   = lpht_pkg::DataBits
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,  // replace, key_in[31:0], hash_in[31:0], data_in[31:0]
  input  logic [1:0]   in_tuser,  // action
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [47:0]  out_tdata  // status[2:0], data_out[31:0], live_count[8:0]
);

  lpht_pkg::cmd_t cmd;
  logic           cmd_valid, cmd_ready;

  lpht_front #(.KEY_BITS(KEY_BITS), .DATA_BITS(DATA_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd));

  lpht_engine #(.TABLE_ORDER(TABLE_ORDER), .KEY_BITS(KEY_BITS), .DATA_BITS(DATA_BITS))
  u_engine (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata));

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
module tb;

  localparam int SLOTS = 1 << lpht_pkg::TableOrder;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [8:0]  count;
    logic [31:0] data;
    logic [2:0]  status;
  } reply_t;

  // Behavioral copy of the table and queue of replies still to arrive.
  class table_scoreboard;
    logic [1:0]  tag [SLOTS];
    logic [31:0] key_mem [SLOTS];
    logic [31:0] data_mem [SLOTS];
    int unsigned live;
    reply_t pending[$];
    int mismatches;

    function void clear_table();
      foreach (tag[i]) tag[i] = lpht_pkg::TAG_EMPTY;
      live = 0;
      mismatches = 0;
    endfunction

    function void note_request(logic [1:0] act, logic repl, logic [31:0] k,
                               logic [31:0] h, logic [31:0] d);
      int at;
      int hit;
      int spot;
      reply_t r;
      hit = -1;
      spot = -1;
      r = '0;
      for (int i = 0; i < SLOTS; i++) begin
        at = (h + i) % SLOTS;
        if (tag[at] == lpht_pkg::TAG_EMPTY) begin
          if (spot < 0) spot = at;
          break;
        end
        if (tag[at] == lpht_pkg::TAG_TOMB) begin
          if (spot < 0) spot = at;
          continue;
        end
        if (key_mem[at] == k) begin
          hit = at;
          break;
        end
      end
      case (act)
        lpht_pkg::ACT_LOOKUP: if (hit >= 0) begin
          r.status = lpht_pkg::ST_FOUND;
          r.data = data_mem[hit];
        end
        lpht_pkg::ACT_INSERT: begin
          if (hit >= 0) begin
            if (repl) data_mem[hit] = d;
            r.status = lpht_pkg::ST_FOUND;
            r.data = data_mem[hit];
          end else if (spot >= 0) begin
            tag[spot] = lpht_pkg::TAG_LIVE;
            key_mem[spot] = k;
            data_mem[spot] = d;
            live++;
            r.status = lpht_pkg::ST_INSERTED;
            r.data = d;
          end else begin
            r.status = lpht_pkg::ST_FULL;
          end
        end
        lpht_pkg::ACT_REMOVE: if (hit >= 0) begin
          tag[hit] = lpht_pkg::TAG_TOMB;
          if (live > 0) live--;
          r.status = lpht_pkg::ST_REMOVED;
        end
        default: ;
      endcase
      r.count = live[8:0];
      pending.push_back(r);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.data !== want.data ||
          got.count !== want.count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: status %0d/%0d data %h/%h count %0d/%0d (exp/got)",
                   want.status, got.status, want.data, got.data, want.count, got.count);
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [103:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [47:0]  out_tdata;

  table_scoreboard sb;
  int idle_cycles = 0;
  int out_hold = 0;
  bit stall_free;

  linear_probe_hash_table_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    if (stall_free) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  // Called at a falling edge; tvalid stays high when words follow back to back.
  task automatic send_word(logic [1:0] act, logic repl, logic [31:0] k,
                           logic [31:0] h, logic [31:0] d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {7'd0, d, h, k, repl};
    do @(posedge clk); while (!in_tready);
    sb.note_request(act, repl, k, h, d);
    @(negedge clk);
  endtask

  // A nonzero pool gives a small key set: frequent hits, removals, collisions.
  task automatic send_random(int pool, int hash_span);
    logic [1:0]  act;
    logic [31:0] k;
    int r;
    r = $urandom_range(0, 99);
    act = (r < 45) ? lpht_pkg::ACT_INSERT : (r < 70) ? lpht_pkg::ACT_LOOKUP :
          (r < 97) ? lpht_pkg::ACT_REMOVE : lpht_pkg::ACT_NOP;
    k = (pool > 0) ? 32'hA5A5_0000 + $urandom_range(0, pool - 1) : $urandom;
    send_word(act, 1'($urandom_range(0, 1)), k,
              (hash_span > 0) ? (k * 7) % hash_span + ($urandom & 32'hFFFF_FF00) : k * 13,
              $urandom);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_reply(out_tdata[43:0]);
  end

  always @(negedge clk) begin
    int g;
    g = $urandom_range(0, 19);
    if (stall_free) begin
      out_hold = 0;
      out_tready <= 1'b1;
    end else if (out_hold > 0) begin
      out_hold = out_hold - 1;
      out_tready <= 1'b0;
    end else if (g == 0) begin
      out_hold = $urandom_range(10, 40);
      out_tready <= 1'b0;
    end else begin
      out_tready <= (g < 5) ? 1'b0 : 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    sb = new();
    sb.clear_table();
    stall_free = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: misses on an empty table, field extremes, every action.
    send_word(lpht_pkg::ACT_LOOKUP, 1'b0, 32'h0, 32'h0, 32'h0);
    send_word(lpht_pkg::ACT_REMOVE, 1'b0, 32'h0, 32'h0, 32'h0);
    send_word(lpht_pkg::ACT_INSERT, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(lpht_pkg::ACT_INSERT, 1'b0, 32'h0, 32'hFFFF_FFFF, 32'h1234_5678);
    send_word(lpht_pkg::ACT_LOOKUP, 1'b0, 32'h0, 32'hFFFF_FFFF, 32'h0);
    send_word(lpht_pkg::ACT_INSERT, 1'b0, 32'h0, 32'hFFFF_FFFF, 32'hDEAD_BEEF);
    send_word(lpht_pkg::ACT_INSERT, 1'b1, 32'h0, 32'hFFFF_FFFF, 32'hCAFE_F00D);
    send_word(lpht_pkg::ACT_REMOVE, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_word(lpht_pkg::ACT_LOOKUP, 1'b0, 32'h0, 32'hFFFF_FFFF, 32'h0);
    send_word(lpht_pkg::ACT_INSERT, 1'b0, 32'h5, 32'hFFFF_FFFF, 32'h5555_5555);
    send_word(lpht_pkg::ACT_NOP, 1'b1, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(lpht_pkg::ACT_REMOVE, 1'b0, 32'h0, 32'hFFFF_FFFF, 32'h0);
    send_word(lpht_pkg::ACT_REMOVE, 1'b0, 32'h5, 32'hFFFF_FFFF, 32'h0);

    // Random mix over a small colliding key pool.
    for (int n = 0; n < 400; n++) begin
      if (n == 250) stall_free = 1'b1;
      if (n == 350) stall_free = 1'b0;
      send_random(48, 16);
    end
    // Fill the whole table to reach the full status, then probe and drain it.
    stall_free = 1'b1;
    for (int n = 0; n < SLOTS + 8; n++)
      send_word(lpht_pkg::ACT_INSERT, 1'b0, 32'h7000_0000 + n, $urandom, $urandom);
    for (int n = 0; n < 10; n++) send_random(0, 0);
    stall_free = 1'b0;
    for (int n = 0; n < 300; n++) send_random(400, 0);
    for (int n = 0; n < SLOTS; n++)
      send_word(lpht_pkg::ACT_REMOVE, 1'b0, 32'h7000_0000 + n, $urandom, 32'h0);
    for (int n = 0; n < 300; n++) send_random(32, 256);
    in_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
